>>> hw/rtl/pei_pkg.sv
`default_nettype none

package pei_pkg;

    // fixed widths of the clamp registers and the stored accumulation
    localparam int CLAMP_W   = 31;
    localparam int ACC_W     = CLAMP_W + 1;
    localparam int SUM_W     = ACC_W + 1;
    localparam int NUM_PARTS = 6;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 31'd16777216;

    // register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_CLAMP    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION_CLAMP = 1'b1;

    // component indexes
    localparam logic [IDX_W-1:0] IDX_FIRST_POS = 3'd0;
    localparam logic [IDX_W-1:0] IDX_LAST_POS  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_FIRST_ROT = 3'd3;
    localparam logic [IDX_W-1:0] IDX_LAST_ROT  = 3'd5;

    // small-error threshold is 1/THRESH_DEN, rounded to nearest
    localparam logic [63:0] THRESH_DEN  = 64'd100000;
    localparam logic [63:0] THRESH_HALF = 64'd50000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_DOT_GO,
        S_DOT_RUN,
        S_DOT_ADD,
        S_CHECK,
        S_SMALL,
        S_PROJ_GO,
        S_MUL_RUN,
        S_DIV_GO,
        S_DIV_RUN,
        S_ROT,
        S_DONE
    } t_state;

    // symmetric saturation to +-lim
    function automatic logic signed [ACC_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [CLAMP_W-1:0]      lim
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [SUM_W-1:0] r;
        hi = $signed({2'b00, lim});
        lo = -hi;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end else begin
            r = v;
        end
        return r[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pei_err_if.sv
`default_nettype none

interface pei_err_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] err_pos_x;
    logic signed [DATA_WIDTH-1:0] err_pos_y;
    logic signed [DATA_WIDTH-1:0] err_pos_z;
    logic signed [DATA_WIDTH-1:0] err_rot_x;
    logic signed [DATA_WIDTH-1:0] err_rot_y;
    logic signed [DATA_WIDTH-1:0] err_rot_z;

    modport source (
        output valid, err_pos_x, err_pos_y, err_pos_z, err_rot_x, err_rot_y, err_rot_z,
        input  ready
    );
    modport sink (
        input  valid, err_pos_x, err_pos_y, err_pos_z, err_rot_x, err_rot_y, err_rot_z,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/pei_acc_if.sv
`default_nettype none

interface pei_acc_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] acc_pos_x;
    logic signed [DATA_WIDTH-1:0] acc_pos_y;
    logic signed [DATA_WIDTH-1:0] acc_pos_z;
    logic signed [DATA_WIDTH-1:0] acc_rot_x;
    logic signed [DATA_WIDTH-1:0] acc_rot_y;
    logic signed [DATA_WIDTH-1:0] acc_rot_z;

    modport source (
        output valid, acc_pos_x, acc_pos_y, acc_pos_z, acc_rot_x, acc_rot_y, acc_rot_z,
        input  ready
    );
    modport sink (
        input  valid, acc_pos_x, acc_pos_y, acc_pos_z, acc_rot_x, acc_rot_y, acc_rot_z,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/pei_smul.sv
`default_nettype none

// unsigned shift-add multiplier, one multiplier bit per cycle
module pei_smul #(
    parameter int A_W = 64,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(B_W - 1);

    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [A_W:0]     step_sum;
    logic [A_W-1:0]   n_hi;
    logic [B_W-1:0]   n_lo;

    // add multiplicand on the low bit, then shift the pair right
    always_comb begin
        step_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
        n_hi     = step_sum[A_W:1];
        n_lo     = {step_sum[0], r_lo[B_W-1:1]};
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire

>>> hw/rtl/pei_sdiv.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
// the starting remainder must be below the divisor
module pei_sdiv #(
    parameter int N_W = 64,
    parameter int Q_W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_rem,
    input  logic [Q_W-1:0] i_low,
    input  logic [N_W-1:0] i_div,
    output logic           o_done,
    output logic [Q_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

    logic [N_W-1:0]   r_rem;
    logic [Q_W-1:0]   r_low;
    logic [N_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [N_W:0]     trial;
    logic [N_W:0]     diff;
    logic             fit;
    logic [N_W-1:0]   n_rem;
    logic [Q_W-1:0]   n_low;

    // bring in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_low[Q_W-1]};
        diff  = trial - {1'b0, r_div};
        fit   = !diff[N_W];
        n_rem = fit ? diff[N_W-1:0] : trial[N_W-1:0];
        n_low = {r_low[Q_W-2:0], fit};
    end

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_div <= i_div;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_low;

endmodule

`default_nettype wire

>>> hw/rtl/pose_error_integrator_clamp.sv
// Pose error integrator with anti-windup clamp.
// i_err (valid/ready) carries one six-part pose error per beat: three position
// and three orientation parts, signed fixed point. o_acc (valid/ready) returns
// one beat of six clamped accumulations per input beat, in order.
// Position parts add to the stored accumulation. Orientation parts either
// replace it (squared error norm below 1e-5) or add the error to the old
// accumulation projected onto the error direction. All parts saturate to the
// clamp registers, written through i_cfg_wr_en / i_cfg_index / i_cfg_data;
// the user must write them only while the block is idle (not enforced).
// One item is worked at a time: the next item is accepted only after the
// result of the last one has been handed to the output register.
// The work is done by the bit-serial multiplier (six passes, three for a
// small orientation error) and the bit-serial divider (three passes, none
// for a small orientation error).
// A finished result sits in an output register; the next item is accepted
// while it waits, and only the final copy waits on a stalled receiver.
// Reset (synchronous, active low) zeroes the accumulation and sets both
// clamps to 1.0; there is no clearing pass.
`default_nettype none

module pose_error_integrator_clamp
    import pei_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pei_err_if.sink              i_err,
    pei_acc_if.source            o_acc,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CLAMP_W-1:0]   i_cfg_data
);

    localparam int NW = ACC_W + DATA_WIDTH;
    localparam int PW = NW + DATA_WIDTH;
    localparam logic [63:0] THRESH_FULL =
        ((64'd1 << (2 * FRAC_BITS)) + THRESH_HALF) / THRESH_DEN;
    localparam logic [NW-1:0] SMALL_THRESH = THRESH_FULL[NW-1:0];

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0]             r_idx;
    logic signed [DATA_WIDTH-1:0] r_err  [NUM_PARTS];
    logic signed [ACC_W-1:0]      r_prev [NUM_PARTS];
    logic signed [DATA_WIDTH-1:0] r_out  [NUM_PARTS];
    logic                         r_out_valid;
    logic [CLAMP_W-1:0]           r_pos_clamp;
    logic [CLAMP_W-1:0]           r_rot_clamp;
    logic [NW-1:0]                r_pos;
    logic [NW-1:0]                r_neg;
    logic [NW-1:0]                r_ee;
    logic [NW-1:0]                r_dmag;
    logic                         r_dneg;

    logic in_take;
    logic out_load;
    logic mul_start;
    logic div_start;
    logic mul_done;
    logic sq_done;
    logic dot_done;
    logic div_done;
    logic last_pos;
    logic last_rot;
    logic small_err;

    logic [PW-1:0]           mul_prod;
    logic [2*DATA_WIDTH-1:0] sq_prod;
    logic [ACC_W-1:0]        quot;
    logic [NW-1:0]           mul_a;

    logic signed [ACC_W-1:0]      cur_prev;
    logic signed [DATA_WIDTH-1:0] cur_err;
    logic [ACC_W-1:0]             prev_u;
    logic [DATA_WIDTH-1:0]        err_u;
    logic                         cur_prev_neg;
    logic                         cur_err_neg;
    logic [ACC_W-1:0]             prev_mag;
    logic [DATA_WIDTH-1:0]        err_mag;

    logic                    proj_neg;
    logic signed [SUM_W-1:0] proj_u;
    logic signed [SUM_W-1:0] proj;
    logic signed [SUM_W-1:0] add_a;
    logic signed [SUM_W-1:0] add_b;
    logic signed [SUM_W-1:0] add_sum;
    logic [CLAMP_W-1:0]      lim;
    logic signed [ACC_W-1:0] clamped;

    // handshakes
    assign in_take = i_err.valid && i_err.ready;

    // current component and magnitudes
    always_comb begin
        cur_prev     = r_prev[r_idx];
        cur_err      = r_err[r_idx];
        prev_u       = cur_prev;
        err_u        = cur_err;
        cur_prev_neg = cur_prev[ACC_W-1];
        cur_err_neg  = cur_err[DATA_WIDTH-1];
        prev_mag     = cur_prev_neg ? -prev_u : prev_u;
        err_mag      = cur_err_neg ? -err_u : err_u;
    end

    assign last_pos  = (r_idx == IDX_LAST_POS);
    assign last_rot  = (r_idx == IDX_LAST_ROT);
    assign small_err = (r_ee < SMALL_THRESH);
    assign dot_done  = mul_done && sq_done;

    // signed projection part and shared add/clamp
    always_comb begin
        proj_neg = r_dneg ^ cur_err_neg;
        proj_u   = $signed({1'b0, quot});
        proj     = proj_neg ? -proj_u : proj_u;
        add_b    = SUM_W'(cur_err);
        if (r_state == S_POS) begin
            add_a = SUM_W'(cur_prev);
            lim   = r_pos_clamp;
        end else if (r_state == S_ROT) begin
            add_a = proj;
            lim   = r_rot_clamp;
        end else begin
            add_a = '0;
            lim   = r_rot_clamp;
        end
        add_sum = add_a + add_b;
        clamped = clamp_sym(add_sum, lim);
    end

    // multiplicand: |prev| for the dot products, |prev.e| for the projection
    assign mul_a = (r_state == S_DOT_GO) ? NW'(prev_mag) : r_dmag;

    pei_smul #(
        .A_W (NW),
        .B_W (DATA_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (err_mag),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    pei_smul #(
        .A_W (DATA_WIDTH),
        .B_W (DATA_WIDTH)
    ) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (err_mag),
        .i_b     (err_mag),
        .o_done  (sq_done),
        .o_prod  (sq_prod)
    );

    // quotient fits ACC_W bits, so the top of the product starts below e.e
    pei_sdiv #(
        .N_W (NW),
        .Q_W (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (NW'(mul_prod[PW-1:ACC_W])),
        .i_low   (mul_prod[ACC_W-1:0]),
        .i_div   (r_ee),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_take) n_state = S_POS;
            S_POS:     if (last_pos) n_state = S_DOT_GO;
            S_DOT_GO:  n_state = S_DOT_RUN;
            S_DOT_RUN: if (dot_done) n_state = S_DOT_ADD;
            S_DOT_ADD: n_state = last_rot ? S_CHECK : S_DOT_GO;
            S_CHECK:   n_state = small_err ? S_SMALL : S_PROJ_GO;
            S_SMALL:   if (last_rot) n_state = S_DONE;
            S_PROJ_GO: n_state = S_MUL_RUN;
            S_MUL_RUN: if (mul_done) n_state = S_DIV_GO;
            S_DIV_GO:  n_state = S_DIV_RUN;
            S_DIV_RUN: if (div_done) n_state = S_ROT;
            S_ROT:     n_state = last_rot ? S_DONE : S_PROJ_GO;
            S_DONE:    if (out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_err.ready = (r_state == S_IDLE);
        mul_start   = (r_state == S_DOT_GO) || (r_state == S_PROJ_GO);
        div_start   = (r_state == S_DIV_GO);
        out_load    = (r_state == S_DONE) && (!r_out_valid || o_acc.ready);
    end

    // control, accumulation state and clamp registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= IDX_FIRST_POS;
            r_out_valid <= 1'b0;
            r_pos_clamp <= CLAMP_RESET;
            r_rot_clamp <= CLAMP_RESET;
            for (int j = 0; j < NUM_PARTS; j++) begin
                r_prev[j] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_POSITION_CLAMP:    r_pos_clamp <= i_cfg_data;
                    REG_ORIENTATION_CLAMP: r_rot_clamp <= i_cfg_data;
                endcase
            end

            if (in_take) begin
                r_idx <= IDX_FIRST_POS;
            end else if (r_state == S_CHECK) begin
                r_idx <= IDX_FIRST_ROT;
            end else if ((r_state == S_POS) || (r_state == S_DOT_ADD) ||
                         (r_state == S_SMALL) || (r_state == S_ROT)) begin
                r_idx <= r_idx + IDX_W'(1);
            end

            if ((r_state == S_POS) || (r_state == S_SMALL) || (r_state == S_ROT)) begin
                r_prev[r_idx] <= clamped;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_acc.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_err[0] <= i_err.err_pos_x;
            r_err[1] <= i_err.err_pos_y;
            r_err[2] <= i_err.err_pos_z;
            r_err[3] <= i_err.err_rot_x;
            r_err[4] <= i_err.err_rot_y;
            r_err[5] <= i_err.err_rot_z;
            r_pos    <= '0;
            r_neg    <= '0;
            r_ee     <= '0;
        end else if (r_state == S_DOT_ADD) begin
            if (cur_prev_neg != cur_err_neg) begin
                r_neg <= r_neg + mul_prod[NW-1:0];
            end else begin
                r_pos <= r_pos + mul_prod[NW-1:0];
            end
            r_ee <= r_ee + NW'(sq_prod);
        end

        if (r_state == S_CHECK) begin
            r_dneg <= (r_neg > r_pos);
            r_dmag <= (r_neg > r_pos) ? (r_neg - r_pos) : (r_pos - r_neg);
        end

        if (out_load) begin
            for (int j = 0; j < NUM_PARTS; j++) begin
                r_out[j] <= r_prev[j][DATA_WIDTH-1:0];
            end
        end
    end

    // result beat
    assign o_acc.valid     = r_out_valid;
    assign o_acc.acc_pos_x = r_out[0];
    assign o_acc.acc_pos_y = r_out[1];
    assign o_acc.acc_pos_z = r_out[2];
    assign o_acc.acc_rot_x = r_out[3];
    assign o_acc.acc_rot_y = r_out[4];
    assign o_acc.acc_rot_z = r_out[5];

endmodule

`default_nettype wire
